FILE: hdl/sem_pkg.sv
`default_nettype none
package sem_pkg;

    localparam int CH_W  = 8;
    localparam int HGT_W = 16;
    localparam int ROW_W = HGT_W + 1;
    localparam int CFG_W = 16;
    localparam int IDX_W = 2;
    localparam int GRD_W = 12;
    localparam int SQS_W = 21;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    localparam logic [SQS_W-1:0] SAT_SQ = 21'd65281;

    typedef struct packed {
        logic            action;
        logic [CH_W-1:0] pixel_red;
        logic [CH_W-1:0] pixel_green;
        logic [CH_W-1:0] pixel_blue;
    } t_pix_beat;

    typedef struct packed {
        logic [CH_W-1:0] edge_red;
        logic [CH_W-1:0] edge_green;
        logic [CH_W-1:0] edge_blue;
        logic            frame_done;
    } t_edge_beat;

    typedef logic [2:0][CH_W-1:0] t_rgb;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SUM,
        S_SQ,
        S_ROOT,
        S_FIN
    } t_state;

endpackage
`default_nettype wire

FILE: hdl/sem_stream_if.sv
`default_nettype none
interface sem_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/sobel_edge_magnitude.sv
// channel    dir  beat contents
// i_pix_if   in   action, pixel_red, pixel_green, pixel_blue
// o_edge_if  out  edge_red, edge_green, edge_blue, frame_done
// i_cfg_*    in   write enable, register index, 16-bit data
//
// An ignored beat is taken in the idle state only. A beat without result also
// passes the row store read. A beat with result then passes the gradient and
// square stages and the 8-step shared square-root loop before it is loaded.
// Reset is synchronous; the row store is not cleared, stale rows are masked.
// A result waits in the output register; the next beat is taken meanwhile.
`default_nettype none
module sobel_edge_magnitude
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 65535
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    sem_stream_if.sink            i_pix_if,
    sem_stream_if.source          o_edge_if,
    input  wire                   i_cfg_wr_en,
    input  wire [IDX_W-1:0]       i_cfg_index,
    input  wire [CFG_W-1:0]       i_cfg_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);

    t_state r_state, n_state;

    logic [2*3*CH_W-1:0] r_row_mem [MAX_WIDTH];
    logic [2*3*CH_W-1:0] r_rd;

    logic [WW-1:0]    r_width;
    logic [HGT_W-1:0] r_height;
    logic [AW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [WW-1:0]    r_drain;

    logic             r_act;
    t_rgb             r_pix;
    t_rgb             r_win [9];
    logic [8:0]       r_mask;
    logic             r_done;

    logic signed [GRD_W-1:0] r_gx [3];
    logic signed [GRD_W-1:0] r_gy [3];
    logic [SQS_W-1:0]        r_sq [3];
    logic [CH_W-1:0]         r_root [3];
    logic [2:0]              r_bit;

    logic       r_out_valid;
    t_edge_beat r_out;

    logic in_ready, accept, ignore, load_out, out_free;

    assign out_free = !r_out_valid || o_edge_if.ready;
    assign accept   = i_pix_if.valid && in_ready;
    assign ignore   = (i_pix_if.data.action == ACT_PIXEL)
                      ? (r_row >= ROW_W'(r_height)) : (r_row < ROW_W'(r_height));

    // center of the window relative to the current raster position
    logic [WW-1:0]    ccol;
    logic [ROW_W-1:0] crow;
    logic             emit;
    logic [2:0]       rok, cok;
    logic             last_col, at_end;

    always_comb begin
        ccol     = (r_col != '0) ? WW'(r_col) - WW'(1) : r_width - WW'(1);
        crow     = (r_col != '0) ? r_row - ROW_W'(1) : r_row - ROW_W'(2);
        emit     = (r_row >= ROW_W'(2)) || (r_row == ROW_W'(1) && r_col != '0);
        rok[0]   = crow != '0;
        rok[1]   = 1'b1;
        rok[2]   = ({1'b0, crow} + (ROW_W+1)'(1)) < (ROW_W+1)'(r_height);
        cok[0]   = ccol != '0;
        cok[1]   = 1'b1;
        cok[2]   = ({1'b0, ccol} + (WW+1)'(1)) < {1'b0, r_width};
        last_col = ({1'b0, r_col} + (AW+1)'(1)) >= (AW+1)'(r_width);
        at_end   = {1'b0, r_drain} + (WW+1)'(1) > {1'b0, r_width};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept && !ignore) n_state = S_READ;
            S_READ: n_state = emit ? S_SUM : S_IDLE;
            S_SUM:  n_state = S_SQ;
            S_SQ:   n_state = S_ROOT;
            S_ROOT: if (r_bit == 3'd0) n_state = S_FIN;
            S_FIN:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            S_IDLE: in_ready = 1'b1;
            S_FIN:  load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // row store: {row two back, row one back} per column
    always_ff @(posedge i_clk) begin
        if (accept) r_rd <= r_row_mem[r_col];
        if (r_state == S_READ) r_row_mem[r_col] <= {r_rd[3*CH_W-1:0], r_pix};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'(MAX_WIDTH < 1024 ? MAX_WIDTH : 1024);
            r_height <= HGT_W'(MAX_HEIGHT < 768 ? MAX_HEIGHT : 768);
            r_col    <= '0;
            r_row    <= '0;
            r_drain  <= '0;
        end else if (i_cfg_wr_en && (i_cfg_index == REG_FRAME_WIDTH ||
                                     i_cfg_index == REG_FRAME_HEIGHT)) begin
            if (i_cfg_index == REG_FRAME_WIDTH) begin
                if (i_cfg_data[10:0] == 11'd0)
                    r_width <= WW'(1);
                else if (32'(i_cfg_data[10:0]) > 32'(MAX_WIDTH))
                    r_width <= WW'(MAX_WIDTH);
                else
                    r_width <= WW'(i_cfg_data[10:0]);
            end else begin
                if (i_cfg_data == '0)
                    r_height <= HGT_W'(1);
                else if (32'(i_cfg_data) > 32'(MAX_HEIGHT))
                    r_height <= HGT_W'(MAX_HEIGHT);
                else
                    r_height <= i_cfg_data;
            end
            r_col   <= '0;
            r_row   <= '0;
            r_drain <= '0;
        end else if (r_state == S_READ) begin
            if (r_act == ACT_DRAIN && at_end) begin
                r_col   <= '0;
                r_row   <= '0;
                r_drain <= '0;
            end else begin
                if (r_act == ACT_DRAIN) r_drain <= r_drain + WW'(1);
                if (last_col) begin
                    r_col <= '0;
                    r_row <= r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act <= i_pix_if.data.action;
            if (i_pix_if.data.action == ACT_DRAIN)
                r_pix <= '0;
            else
                r_pix <= {i_pix_if.data.pixel_red, i_pix_if.data.pixel_green,
                          i_pix_if.data.pixel_blue};
        end
        if (r_state == S_READ) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]   <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
                for (int c = 0; c < 3; c++) r_mask[r*3+c] <= rok[r] & cok[c];
            end
            r_win[2] <= r_rd[2*3*CH_W-1:3*CH_W];
            r_win[5] <= r_rd[3*CH_W-1:0];
            r_win[8] <= r_pix;
            r_done   <= (crow == ROW_W'(r_height) - ROW_W'(1)) &&
                        (ccol == r_width - WW'(1));
        end
    end

    // gradient, squares, root
    logic signed [GRD_W-1:0] tap [9][3];
    logic [CH_W-1:0]         trial [3];

    always_comb begin
        for (int k = 0; k < 9; k++)
            for (int c = 0; c < 3; c++)
                tap[k][c] = r_mask[k] ? GRD_W'(r_win[k][c]) : '0;
        for (int c = 0; c < 3; c++)
            trial[c] = r_root[c] | (CH_W'(1) << r_bit);
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_SUM: begin
                for (int c = 0; c < 3; c++) begin
                    r_gx[c] <= tap[2][c] - tap[0][c] + ((tap[5][c] - tap[3][c]) <<< 1)
                               + tap[8][c] - tap[6][c];
                    r_gy[c] <= tap[6][c] + (tap[7][c] <<< 1) + tap[8][c]
                               - tap[0][c] - (tap[1][c] <<< 1) - tap[2][c];
                end
            end
            S_SQ: begin
                for (int c = 0; c < 3; c++) begin
                    r_sq[c]   <= SQS_W'(22'(r_gx[c] * r_gx[c]) + 22'(r_gy[c] * r_gy[c]));
                    r_root[c] <= '0;
                end
                r_bit <= 3'd7;
            end
            S_ROOT: begin
                for (int c = 0; c < 3; c++)
                    if (SQS_W'({8'd0, trial[c]} * {8'd0, trial[c]}) <= r_sq[c])
                        r_root[c] <= trial[c];
                r_bit <= r_bit - 3'd1;
            end
            default: ;
        endcase
    end

    logic [CH_W-1:0] mag [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_sq[c] >= SAT_SQ)
                mag[c] = '1;
            else if (r_sq[c] > SQS_W'({8'd0, r_root[c]} * {8'd0, r_root[c]})
                               + SQS_W'(r_root[c]))
                mag[c] = r_root[c] + CH_W'(1);
            else
                mag[c] = r_root[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_edge_if.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.edge_red   <= mag[2];
            r_out.edge_green <= mag[1];
            r_out.edge_blue  <= mag[0];
            r_out.frame_done <= r_done;
        end
    end

    assign i_pix_if.ready  = in_ready;
    assign o_edge_if.valid = r_out_valid;
    assign o_edge_if.data  = r_out;

    a_col_in_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (AW+1)'(r_col) < (AW+1)'(r_width))
        else $error("column counter beyond frame width");

    a_drain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain <= r_width)
        else $error("drain count beyond frame width");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= ROW_W'(r_height) + ROW_W'(1))
        else $error("row counter beyond frame end");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && !o_edge_if.ready) |=> r_state == S_FIN)
        else $error("result dropped while output stalled");

endmodule
`default_nettype wire
